// ===== rtl/lcm3_pkg.sv =====
// ---------------------------------------------------------------------------
// lcm3_pkg: shared constants and types
// Widths, sequencer states and divider status for the three-operand LCM block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcm3_pkg;

   // Working width of the operands and of the trial factor.
   localparam int WIDTH  = 16;
   // Width of the operand ports and of the result port.
   localparam int IN_W   = 16;
   localparam int OUT_W  = 48;
   // The running product stays below 2^(3*WIDTH).
   localparam int PROD_W = 3 * WIDTH;
   // Divider step counter, able to hold WIDTH itself.
   localparam int CNT_W  = $clog2(WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PICK,
      ST_WAIT,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage : lcm3_pkg

`default_nettype wire

// ===== rtl/lcm3_div.sv =====
// ---------------------------------------------------------------------------
// lcm3_div: shared serial divider
// Restoring division, one quotient bit per cycle; gives quotient and remainder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcm3_div
   import lcm3_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic      [WIDTH-1:0] quotient,
   output logic      [WIDTH-1:0] remainder,
   output div_stat_type          status
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [WIDTH-1:0] rem_ff,  rem_in;
   logic [WIDTH-1:0] quo_ff,  quo_in;
   logic [WIDTH-1:0] div_ff,  div_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits WIDTH bits.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = WIDTH'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule : lcm3_div

`default_nettype wire

// ===== rtl/lcm_of_three_trial_division.sv =====
// ---------------------------------------------------------------------------
// lcm_of_three_trial_division: least common multiple of three operands
// A sequencer drives one serial divider over trial factors 2, 3, 4, ...
// ---------------------------------------------------------------------------
// Usage:
//   An item enters on req_ (three unsigned operands) with valid/ready, and one
//   result item leaves on rsp_ (the 48-bit multiple and a zero flag). If any
//   operand is zero, the result is multiple 0 with rsp_zero_error set, offered
//   on rsp_valid from the output register once the sequencer reaches ST_DONE.
//   Otherwise every trial factor f costs up to three divisions, one per
//   operand still above 1, plus bookkeeping in ST_NEXT and ST_CHECK; a
//   factor that divides is tried again at once. The time per item thus
//   grows with the largest prime factor P of the operands, and the serial
//   divider sets most of it.
//   req_ready is high only while the sequencer is idle, so one item is in
//   work at a time. The result sits in an output register; while the
//   receiver stalls, the next item may still be taken and worked on, and
//   it waits for the register to free before it is written.
//   Reset clears the sequencer, the divider status and the output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcm_of_three_trial_division
   import lcm3_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [IN_W-1:0] req_first_value,
   input  wire logic [IN_W-1:0] req_second_value,
   input  wire logic [IN_W-1:0] req_third_value,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [OUT_W-1:0]     rsp_multiple,
   output logic                 rsp_zero_error
);

   state_type         state_ff, state_in;
   logic [WIDTH-1:0]  val0_ff, val0_in;
   logic [WIDTH-1:0]  val1_ff, val1_in;
   logic [WIDTH-1:0]  val2_ff, val2_in;
   logic [1:0]        idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic              err_ff, err_in;
   logic [WIDTH-1:0]  factor_ff, factor_in;
   logic [PROD_W-1:0] product_ff, product_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_multiple_ff, rsp_multiple_in;
   logic              rsp_error_ff, rsp_error_in;

   logic [WIDTH-1:0]  cur_val;
   logic              div_start;
   logic [WIDTH-1:0]  div_quo;
   logic [WIDTH-1:0]  div_rem;
   div_stat_type      div_stat;
   logic              accept;
   logic              all_ones;
   logic              any_zero;
   logic [WIDTH-1:0]  in0, in1, in2;

   lcm3_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cur_val),
      .divisor   (factor_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_stat)
   );

   assign in0      = WIDTH'(req_first_value);
   assign in1      = WIDTH'(req_second_value);
   assign in2      = WIDTH'(req_third_value);
   assign any_zero = (in0 == '0) || (in1 == '0) || (in2 == '0);
   assign accept   = req_valid && req_ready;
   assign all_ones = (val0_ff == WIDTH'(1)) && (val1_ff == WIDTH'(1)) &&
                     (val2_ff == WIDTH'(1));

   always_comb begin
      case (idx_ff)
         2'd0:    cur_val = val0_ff;
         2'd1:    cur_val = val1_ff;
         default: cur_val = val2_ff;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      val0_in         = val0_ff;
      val1_in         = val1_ff;
      val2_in         = val2_ff;
      idx_in          = idx_ff;
      hit_in          = hit_ff;
      err_in          = err_ff;
      factor_in       = factor_ff;
      product_in      = product_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_multiple_in = rsp_multiple_ff;
      rsp_error_in    = rsp_error_ff;
      div_start       = 1'b0;
      req_ready       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               val0_in    = in0;
               val1_in    = in1;
               val2_in    = in2;
               err_in     = any_zero;
               factor_in  = WIDTH'(2);
               product_in = PROD_W'(1);
               idx_in     = 2'd0;
               hit_in     = 1'b0;
               state_in   = any_zero ? ST_DONE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            idx_in   = 2'd0;
            hit_in   = 1'b0;
            state_in = all_ones ? ST_DONE : ST_PICK;
         end
         ST_PICK: begin
            // A value of one cannot be divided by any factor of two or more.
            if (cur_val == WIDTH'(1)) begin
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd2) ? ST_NEXT : ST_PICK;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               if (div_rem == '0) begin
                  hit_in = 1'b1;
                  case (idx_ff)
                     2'd0:    val0_in = div_quo;
                     2'd1:    val1_in = div_quo;
                     default: val2_in = div_quo;
                  endcase
               end
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd2) ? ST_NEXT : ST_PICK;
            end
         end
         ST_NEXT: begin
            // A factor that divided is tried again before moving on.
            if (hit_ff) begin
               product_in = PROD_W'(product_ff * factor_ff);
            end else begin
               factor_in = factor_ff + WIDTH'(1);
            end
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_multiple_in = err_ff ? '0 : OUT_W'(product_ff);
               rsp_error_in    = err_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val0_ff         <= val0_in;
      val1_ff         <= val1_in;
      val2_ff         <= val2_in;
      idx_ff          <= idx_in;
      hit_ff          <= hit_in;
      err_ff          <= err_in;
      factor_ff       <= factor_in;
      product_ff      <= product_in;
      rsp_multiple_ff <= rsp_multiple_in;
      rsp_error_ff    <= rsp_error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_multiple   = rsp_multiple_ff;
   assign rsp_zero_error = rsp_error_ff;

   // An error result always carries a zero multiple.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_error |-> rsp_multiple == '0)
      else $error("zero_error result with nonzero multiple");

   // The divider runs only while the sequencer waits on it.
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_WAIT)
      else $error("divider busy outside the wait state");

   // A taken item always leaves the idle state.
   a_accept_leaves: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("item taken but sequencer stayed idle");

   // Trial factors never drop below two while dividing.
   a_factor_min: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PICK |-> factor_ff >= WIDTH'(2))
      else $error("trial factor below two");

endmodule : lcm_of_three_trial_division

`default_nettype wire
